// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the FDTD grid stepper.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/fdtd_pkg.sv -----
// Package for the FDTD 2-D TE grid stepper: field types, widths and defaults.
// Depends on nothing.
`default_nettype none
package fdtd_pkg;
    localparam int VALUE_W  = 32;
    localparam int GAIN_W   = 16;
    localparam int COORD_W  = 6;
    localparam int CFG_IDX_W = 2;

    localparam int GRID_N_DEF = 64;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [GAIN_W-1:0]         t_gain;
    typedef logic [COORD_W-1:0]        t_coord;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_H_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_E_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_COL = 2'd3;

    // Reset values of the configuration registers
    localparam t_gain  H_GAIN_RST  = 16'd34755;
    localparam t_gain  E_GAIN_RST  = 16'd34755;
    localparam t_coord SRC_ROW_RST = 6'd32;
    localparam t_coord SRC_COL_RST = 6'd48;

    // Input op codes
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_READ = 1'b1;
endpackage
`default_nettype wire

// ----- hdl/fdtd_2d_te_grid_step.sv -----
// Usage notes:
// Input channel (i_in_valid / o_in_stall) takes a transaction with an op:
// OP_STEP advances the Yee grid one time step, OP_READ returns one cell.
// Output channel (o_out_valid / i_out_stall) returns one transaction per
// input: Ex, Ey, Hz of the read cell (or of the source cell after a step)
// and the step's saturation flag.
// The Ex, Ey and Hz grids sit in three single-write, dual-read memories.
// A step streams three passes through a four-stage read / difference /
// multiply / round-saturate-write pipeline, one cell per cycle:
// (N-1)^2 Hz cells, N*(N-1) Ex cells, N*(N-1) Ey cells, plus a pipeline
// drain after each pass, one source cell and a final read.
// One transaction is in work at a time; the next input transaction is taken
// while a finished result still waits in the output register.
// After reset a clearing pass writes zero to all N*N cells (4096 for
// N = 64); o_in_stall stays high meanwhile, configuration writes are taken.
// A stalled result holds; the final read waits for room.
// Depends on fdtd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fdtd_2d_te_grid_step #(
    parameter int GRID_N = fdtd_pkg::GRID_N_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration
    input  wire logic                       i_cfg_we,
    input  wire logic [fdtd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [fdtd_pkg::GAIN_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_op,
    input  wire fdtd_pkg::t_value           i_source_value,
    input  wire fdtd_pkg::t_coord           i_cell_row,
    input  wire fdtd_pkg::t_coord           i_cell_col,
    // output channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output fdtd_pkg::t_value                o_ex_value,
    output fdtd_pkg::t_value                o_ey_value,
    output fdtd_pkg::t_value                o_hz_value,
    output logic                            o_saturated
);
    import fdtd_pkg::*;

    localparam int CELLS = GRID_N * GRID_N;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(GRID_N);
    localparam int DW    = VALUE_W + 2;          // exact difference width
    localparam int GW    = GAIN_W + 2;           // signed gain, holds 2^GAIN_W
    localparam int PW    = DW + GW;              // product width
    localparam int SW    = PW - GAIN_W + 1;      // own value +/- rounded delta

    localparam logic [AW-1:0] N_A      = AW'(GRID_N);
    localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
    localparam logic [RW-1:0] IDX_LAST = RW'(GRID_N - 1);
    localparam logic [RW-1:0] IDX_PEN  = RW'(GRID_N - 2);

    // sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_PASS   = 3'd2;
    localparam logic [2:0] ST_WAIT   = 3'd3;
    localparam logic [2:0] ST_FETCH  = 3'd4;
    localparam logic [2:0] ST_FETCH2 = 3'd5;

    // pass codes
    localparam logic [1:0] PS_HZ  = 2'd0;
    localparam logic [1:0] PS_EX  = 2'd1;
    localparam logic [1:0] PS_EY  = 2'd2;
    localparam logic [1:0] PS_SRC = 2'd3;

    localparam logic signed [GW-1:0] GAIN_ONE = GW'(1 << GAIN_W);
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1 << (GAIN_W - 1));
    localparam logic signed [SW-1:0] SAT_MAX = SW'({1'b0, {(VALUE_W-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_MIN = -SW'({1'b0, {(VALUE_W-1){1'b1}}}) - SW'(1);

    // configuration registers
    t_gain  r_h_gain, r_e_gain;
    t_coord r_src_row, r_src_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_gain  <= H_GAIN_RST;
            r_e_gain  <= E_GAIN_RST;
            r_src_row <= SRC_ROW_RST;
            r_src_col <= SRC_COL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_H_GAIN:  r_h_gain  <= i_cfg_data;
                CFG_E_GAIN:  r_e_gain  <= i_cfg_data;
                CFG_SRC_ROW: r_src_row <= i_cfg_data[COORD_W-1:0];
                CFG_SRC_COL: r_src_col <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    logic src_on;
    logic [AW-1:0] src_addr;
    assign src_on   = (int'(r_src_row) < GRID_N) && (int'(r_src_col) < GRID_N);
    assign src_addr = AW'(r_src_row) * N_A + AW'(r_src_col);

    // sequencer registers
    logic [2:0]    r_state, n_state;
    logic [1:0]    r_pass, n_pass;
    logic [RW-1:0] r_row, n_row, r_col, n_col;
    logic [AW-1:0] r_clr, n_clr;
    logic [AW-1:0] r_res_addr, n_res_addr;
    logic          r_res_zero, n_res_zero;
    logic          r_is_step, n_is_step;
    t_value        r_src_val;
    logic          r_sat;

    // pipeline registers
    logic          r_v1, r_v2, r_v3;
    logic [1:0]    r_p1, r_p2, r_p3;
    logic [AW-1:0] r_a1, r_a2, r_a3;
    logic signed [DW-1:0] r_d;
    logic signed [GW-1:0] r_g;
    t_value        r_own2, r_own3;
    logic signed [PW-1:0] r_prod;

    // output registers
    logic   r_out_valid;
    t_value r_ex_out, r_ey_out, r_hz_out;
    logic   r_sat_out;

    logic in_acc, out_free, issue, pipe_empty;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign pipe_empty = !r_v1 && !r_v2 && !r_v3;
    assign issue      = (r_state == ST_PASS);

    // per-pass scan bounds
    function automatic logic [RW-1:0] row_lo(input logic [1:0] p);
        return (p == PS_EY) ? RW'(1) : RW'(0);
    endfunction
    function automatic logic [RW-1:0] col_lo(input logic [1:0] p);
        return (p == PS_EX) ? RW'(1) : RW'(0);
    endfunction

    logic [RW-1:0] row_hi, col_hi;
    assign row_hi = (r_pass == PS_HZ) ? IDX_PEN : IDX_LAST;
    assign col_hi = (r_pass == PS_HZ) ? IDX_PEN : IDX_LAST;

    // current cell address and its neighbors; result cell held while fetching
    logic [AW-1:0] k, ra_a, ra_ey_b, ra_ex_b, ra_hz_b;
    assign k       = (r_pass == PS_SRC) ? src_addr : (AW'(r_row) * N_A + AW'(r_col));
    assign ra_a    = ((r_state == ST_FETCH) || (r_state == ST_FETCH2)) ? r_res_addr : k;
    assign ra_ey_b = k + N_A;
    assign ra_ex_b = k + AW'(1);
    assign ra_hz_b = (r_pass == PS_EX) ? (k - AW'(1)) : (k - N_A);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_pass     = r_pass;
        n_row      = r_row;
        n_col      = r_col;
        n_clr      = r_clr;
        n_res_addr = r_res_addr;
        n_res_zero = r_res_zero;
        n_is_step  = r_is_step;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == LAST_A) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_op == OP_READ) begin
                        n_is_step  = 1'b0;
                        n_res_zero = !((int'(i_cell_row) < GRID_N) &&
                                       (int'(i_cell_col) < GRID_N));
                        n_res_addr = AW'(i_cell_row) * N_A + AW'(i_cell_col);
                        n_state    = ST_FETCH;
                    end else begin
                        n_is_step = 1'b1;
                        n_pass    = PS_HZ;
                        n_row     = row_lo(PS_HZ);
                        n_col     = col_lo(PS_HZ);
                        n_state   = ST_PASS;
                    end
                end
            end
            ST_PASS: begin
                if (r_pass == PS_SRC) begin
                    n_state = ST_WAIT;
                end else if (r_col == col_hi) begin
                    n_col = col_lo(r_pass);
                    n_row = r_row + RW'(1);
                    if (r_row == row_hi) n_state = ST_WAIT;
                end else begin
                    n_col = r_col + RW'(1);
                end
            end
            ST_WAIT: begin
                if (pipe_empty) begin
                    unique case (r_pass)
                        PS_HZ, PS_EX: begin
                            n_pass  = r_pass + 2'd1;
                            n_row   = row_lo(r_pass + 2'd1);
                            n_col   = col_lo(r_pass + 2'd1);
                            n_state = ST_PASS;
                        end
                        PS_EY: begin
                            n_res_addr = src_addr;
                            n_res_zero = !src_on;
                            if (src_on) begin
                                n_pass  = PS_SRC;
                                n_state = ST_PASS;
                            end else begin
                                n_state = ST_FETCH;
                            end
                        end
                        default: n_state = ST_FETCH;
                    endcase
                end
            end
            ST_FETCH: n_state = ST_FETCH2;
            ST_FETCH2: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_pass  <= PS_HZ;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pass  <= n_pass;
        end
        r_row      <= n_row;
        r_col      <= n_col;
        r_res_addr <= n_res_addr;
        r_res_zero <= n_res_zero;
        r_is_step  <= n_is_step;
        if (in_acc) r_src_val <= i_source_value;
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // write-back stage: round half up, add or subtract, saturate
    logic signed [SW-1:0] delta, sum;
    logic                 clip_hi, clip_lo;
    t_value               wb_val;
    assign delta   = SW'((r_prod + ROUND_HALF) >>> GAIN_W);
    assign sum     = ((r_p3 == PS_EX) || (r_p3 == PS_SRC)) ?
                     (SW'(r_own3) + delta) : (SW'(r_own3) - delta);
    assign clip_hi = sum > SAT_MAX;
    assign clip_lo = sum < SAT_MIN;
    assign wb_val  = clip_hi ? t_value'(SAT_MAX[VALUE_W-1:0]) :
                     clip_lo ? t_value'(SAT_MIN[VALUE_W-1:0]) : sum[VALUE_W-1:0];

    // memory write ports
    logic          we_ex, we_ey, we_hz;
    logic [AW-1:0] wa;
    t_value        wd;
    always_comb begin
        if (r_state == ST_CLEAR) begin
            we_ex = 1'b1;
            we_ey = 1'b1;
            we_hz = 1'b1;
            wa    = r_clr;
            wd    = '0;
        end else begin
            we_hz = r_v3 && (r_p3 == PS_HZ);
            we_ex = r_v3 && (r_p3 == PS_EX);
            we_ey = r_v3 && ((r_p3 == PS_EY) || (r_p3 == PS_SRC));
            wa    = r_a3;
            wd    = wb_val;
        end
    end

    // field memories: one write, two registered reads each
    t_value mem_ex [CELLS];
    t_value mem_ey [CELLS];
    t_value mem_hz [CELLS];
    t_value ex_a, ex_b, ey_a, ey_b, hz_a, hz_b;

    always_ff @(posedge i_clk) begin
        if (we_ex) mem_ex[wa] <= wd;
        ex_a <= mem_ex[ra_a];
        ex_b <= mem_ex[ra_ex_b];
    end
    always_ff @(posedge i_clk) begin
        if (we_ey) mem_ey[wa] <= wd;
        ey_a <= mem_ey[ra_a];
        ey_b <= mem_ey[ra_ey_b];
    end
    always_ff @(posedge i_clk) begin
        if (we_hz) mem_hz[wa] <= wd;
        hz_a <= mem_hz[ra_a];
        hz_b <= mem_hz[ra_hz_b];
    end

    // difference stage
    logic signed [DW-1:0] d1;
    logic signed [GW-1:0] g1;
    t_value               own1;
    always_comb begin
        unique case (r_p1)
            PS_HZ: begin
                d1   = (DW'(ey_b) - DW'(ey_a)) - (DW'(ex_b) - DW'(ex_a));
                own1 = hz_a;
                g1   = GW'($signed({2'b00, r_h_gain}));
            end
            PS_EX: begin
                d1   = DW'(hz_a) - DW'(hz_b);
                own1 = ex_a;
                g1   = GW'($signed({2'b00, r_e_gain}));
            end
            PS_EY: begin
                d1   = DW'(hz_a) - DW'(hz_b);
                own1 = ey_a;
                g1   = GW'($signed({2'b00, r_e_gain}));
            end
            default: begin
                d1   = DW'(r_src_val);
                own1 = ey_a;
                g1   = GAIN_ONE;
            end
        endcase
    end

    // pipeline control and data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_p1   <= r_pass;
        r_a1   <= k;
        r_p2   <= r_p1;
        r_a2   <= r_a1;
        r_d    <= d1;
        r_g    <= g1;
        r_own2 <= own1;
        r_p3   <= r_p2;
        r_a3   <= r_a2;
        r_prod <= PW'(r_d) * PW'(r_g);
        r_own3 <= r_own2;
    end

    // step saturation flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (in_acc && i_op == OP_STEP) begin
            r_sat <= 1'b0;
        end else if (r_v3 && (clip_hi || clip_lo)) begin
            r_sat <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FETCH2 && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == ST_FETCH2 && out_free) begin
            r_ex_out  <= r_res_zero ? '0 : ex_a;
            r_ey_out  <= r_res_zero ? '0 : ey_a;
            r_hz_out  <= r_res_zero ? '0 : hz_a;
            r_sat_out <= r_is_step && r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ex_value  = r_ex_out;
    assign o_ey_value  = r_ey_out;
    assign o_hz_value  = r_hz_out;
    assign o_saturated = r_sat_out;

    // checks
    `ASSERT_SAME(a_idle_pipe_empty, i_clk, i_rst_n, r_state == ST_IDLE, pipe_empty)
    `ASSERT_SAME(a_clear_no_out, i_clk, i_rst_n, r_state == ST_CLEAR, !r_out_valid && !r_v3)
    `ASSERT_NEXT(a_step_sat_cleared, i_clk, i_rst_n, in_acc && i_op == OP_STEP, !r_sat)
endmodule
`default_nettype wire
